### rtl/core/phase_field_thermo_point_top_defines.svh
`ifndef PHASE_FIELD_THERMO_POINT_TOP_DEFINES_SVH
`define PHASE_FIELD_THERMO_POINT_TOP_DEFINES_SVH

// overlapping implication, checked outside reset
`define PFTP_ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
		else $error("pftp check failed");

// next-cycle implication, checked outside reset
`define PFTP_ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> cons) \
		else $error("pftp check failed");

`endif

### rtl/core/pftp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pftp_pkg;

	localparam int DATA_W    = 32;
	localparam int SUM_W     = 36;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [DATA_W-1:0] fix_t;
	typedef logic signed [SUM_W-1:0]  acc_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	localparam cfg_idx_t CFG_COEF_A     = 3'd0;
	localparam cfg_idx_t CFG_COEF_B     = 3'd1;
	localparam cfg_idx_t CFG_COEF_KAPPA = 3'd2;
	localparam cfg_idx_t CFG_COEF_C     = 3'd3;

	typedef struct packed {
		fix_t phi_value;
		fix_t grad_x;
		fix_t grad_y;
		fix_t grad_z;
		fix_t laplacian;
		fix_t biharmonic;
		fix_t lap_grad_x;
		fix_t lap_grad_y;
		fix_t lap_grad_z;
	} site_t;

	typedef struct packed {
		fix_t free_energy;
		fix_t chem_potential;
		fix_t stress_xx;
		fix_t stress_yy;
		fix_t stress_zz;
		fix_t stress_xy;
		fix_t stress_xz;
		fix_t stress_yz;
	} result_t;

	typedef struct packed {
		fix_t a;
		fix_t b;
		fix_t kappa;
		fix_t c;
	} coef_t;

	function automatic acc_t ext_fix(input fix_t v);
		return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	function automatic fix_t sat_fix(input acc_t v);
		fix_t r;
		if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
			r = v[DATA_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

	// one half times v, rounded half up: floor((v + 1) / 2)
	function automatic fix_t half_q(input fix_t v);
		logic [DATA_W:0] t;
		t = {v[DATA_W-1], v} + (DATA_W+1)'(1);
		return t[DATA_W:1];
	endfunction

	// one quarter times v: floor((v + 2) / 4)
	function automatic fix_t quarter_q(input fix_t v);
		logic [DATA_W+1:0] t;
		t = {{2{v[DATA_W-1]}}, v} + (DATA_W+2)'(2);
		return t[DATA_W+1:2];
	endfunction

	// three quarters times v: floor((3v + 2) / 4)
	function automatic fix_t three_q(input fix_t v);
		logic [DATA_W+1:0] e;
		logic [DATA_W+1:0] t;
		e = {{2{v[DATA_W-1]}}, v};
		t = {e[DATA_W:0], 1'b0} + e + (DATA_W+2)'(2);
		return t[DATA_W+1:2];
	endfunction

endpackage

`default_nettype wire

### rtl/core/pftp_qmul.sv
`timescale 1ns / 1ps
`default_nettype none

module pftp_qmul #(
	parameter int FRAC_BITS = 16
) (
	input  pftp_pkg::fix_t x,
	input  pftp_pkg::fix_t y,
	output pftp_pkg::fix_t p
);

	localparam int PROD_W = 2 * pftp_pkg::DATA_W;
	localparam int DW     = pftp_pkg::DATA_W;
	localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rnd_sum;
	logic signed [PROD_W-1:0] shr;

	assign prod    = PROD_W'(x) * PROD_W'(y);
	assign rnd_sum = prod + RND;
	assign shr     = rnd_sum >>> FRAC_BITS;

	always_comb begin
		if ((&shr[PROD_W-1:DW-1]) || !(|shr[PROD_W-1:DW-1])) begin
			p = shr[DW-1:0];
		end else if (shr[PROD_W-1]) begin
			p = {1'b1, {(DW-1){1'b0}}};
		end else begin
			p = {1'b0, {(DW-1){1'b1}}};
		end
	end

endmodule

`default_nettype wire

### rtl/core/pftp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pftp_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  pftp_pkg::cfg_idx_t  wr_index,
	input  pftp_pkg::fix_t      wr_data,
	output pftp_pkg::coef_t     coef
);

	pftp_pkg::coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				pftp_pkg::CFG_COEF_A:     coef_q.a     <= wr_data;
				pftp_pkg::CFG_COEF_B:     coef_q.b     <= wr_data;
				pftp_pkg::CFG_COEF_KAPPA: coef_q.kappa <= wr_data;
				pftp_pkg::CFG_COEF_C:     coef_q.c     <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

### rtl/core/pftp_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module pftp_pipe #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  pftp_pkg::site_t   site,
	input  pftp_pkg::coef_t   coef,
	output logic              out_vld,
	output pftp_pkg::result_t result
);

	localparam int N_PAIR = 6;
	localparam int PA [N_PAIR] = '{0, 1, 2, 0, 0, 1};
	localparam int PB [N_PAIR] = '{0, 1, 2, 1, 2, 2};

	localparam int M1_PHI2   = 0;
	localparam int M1_PHILAP = 1;
	localparam int M1_PHIBIH = 2;
	localparam int M1_LAP2   = 3;
	localparam int M1_APHI   = 4;
	localparam int M1_KLAP   = 5;
	localparam int M1_CBIH   = 6;
	localparam int M1_GG     = 7;
	localparam int M1_GL     = M1_GG + N_PAIR;
	localparam int N_M1      = M1_GL + 9;

	localparam int M2_PHI3  = 0;
	localparam int M2_PHI4  = 1;
	localparam int M2_APHI2 = 2;
	localparam int M2_KPL   = 3;
	localparam int M2_CPB   = 4;
	localparam int M2_CLAP2 = 5;
	localparam int M2_KGG   = 6;
	localparam int N_M2     = M2_KGG + N_PAIR;

	localparam int M3_BPHI4 = 0;
	localparam int M3_BPHI3 = 1;
	localparam int M3_KGGS  = 2;
	localparam int M3_CGL   = 3;
	localparam int M3_CCR   = 4;
	localparam int N_M3     = M3_CCR + N_PAIR;

	pftp_pkg::fix_t g [3];
	pftp_pkg::fix_t l [3];

	assign g[0] = site.grad_x;
	assign g[1] = site.grad_y;
	assign g[2] = site.grad_z;
	assign l[0] = site.lap_grad_x;
	assign l[1] = site.lap_grad_y;
	assign l[2] = site.lap_grad_z;

	// stage 1: products of the raw site values
	pftp_pkg::fix_t m1_x [N_M1];
	pftp_pkg::fix_t m1_y [N_M1];
	pftp_pkg::fix_t m1_p [N_M1];

	always_comb begin
		m1_x[M1_PHI2]   = site.phi_value;
		m1_y[M1_PHI2]   = site.phi_value;
		m1_x[M1_PHILAP] = site.phi_value;
		m1_y[M1_PHILAP] = site.laplacian;
		m1_x[M1_PHIBIH] = site.phi_value;
		m1_y[M1_PHIBIH] = site.biharmonic;
		m1_x[M1_LAP2]   = site.laplacian;
		m1_y[M1_LAP2]   = site.laplacian;
		m1_x[M1_APHI]   = coef.a;
		m1_y[M1_APHI]   = site.phi_value;
		m1_x[M1_KLAP]   = coef.kappa;
		m1_y[M1_KLAP]   = site.laplacian;
		m1_x[M1_CBIH]   = coef.c;
		m1_y[M1_CBIH]   = site.biharmonic;
		for (int p = 0; p < N_PAIR; p++) begin
			m1_x[M1_GG + p] = g[PA[p]];
			m1_y[M1_GG + p] = g[PB[p]];
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				m1_x[M1_GL + 3*i + j] = g[i];
				m1_y[M1_GL + 3*i + j] = l[j];
			end
		end
	end

	for (genvar k = 0; k < N_M1; k++) begin : g_m1
		pftp_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
			.x(m1_x[k]),
			.y(m1_y[k]),
			.p(m1_p[k])
		);
	end

	logic           vld_s1;
	pftp_pkg::fix_t m1_s1 [N_M1];
	pftp_pkg::fix_t phi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		m1_s1  <= m1_p;
		phi_s1 <= site.phi_value;
	end

	// stage 2: dot products, cross sums, second-level products
	pftp_pkg::fix_t m2_x [N_M2];
	pftp_pkg::fix_t m2_y [N_M2];
	pftp_pkg::fix_t m2_p [N_M2];
	pftp_pkg::fix_t gg2;
	pftp_pkg::fix_t gl2;
	pftp_pkg::fix_t cross2 [N_PAIR];

	always_comb begin
		gg2 = pftp_pkg::sat_fix(pftp_pkg::ext_fix(m1_s1[M1_GG])
			+ pftp_pkg::ext_fix(m1_s1[M1_GG + 1])
			+ pftp_pkg::ext_fix(m1_s1[M1_GG + 2]));
		gl2 = pftp_pkg::sat_fix(pftp_pkg::ext_fix(m1_s1[M1_GL])
			+ pftp_pkg::ext_fix(m1_s1[M1_GL + 4])
			+ pftp_pkg::ext_fix(m1_s1[M1_GL + 8]));
		for (int p = 0; p < N_PAIR; p++) begin
			cross2[p] = pftp_pkg::sat_fix(
				pftp_pkg::ext_fix(m1_s1[M1_GL + 3*PA[p] + PB[p]])
				+ pftp_pkg::ext_fix(m1_s1[M1_GL + 3*PB[p] + PA[p]]));
		end
		m2_x[M2_PHI3]  = m1_s1[M1_PHI2];
		m2_y[M2_PHI3]  = phi_s1;
		m2_x[M2_PHI4]  = m1_s1[M1_PHI2];
		m2_y[M2_PHI4]  = m1_s1[M1_PHI2];
		m2_x[M2_APHI2] = coef.a;
		m2_y[M2_APHI2] = m1_s1[M1_PHI2];
		m2_x[M2_KPL]   = coef.kappa;
		m2_y[M2_KPL]   = m1_s1[M1_PHILAP];
		m2_x[M2_CPB]   = coef.c;
		m2_y[M2_CPB]   = m1_s1[M1_PHIBIH];
		m2_x[M2_CLAP2] = coef.c;
		m2_y[M2_CLAP2] = m1_s1[M1_LAP2];
		for (int p = 0; p < N_PAIR; p++) begin
			m2_x[M2_KGG + p] = coef.kappa;
			m2_y[M2_KGG + p] = m1_s1[M1_GG + p];
		end
	end

	for (genvar k = 0; k < N_M2; k++) begin : g_m2
		pftp_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
			.x(m2_x[k]),
			.y(m2_y[k]),
			.p(m2_p[k])
		);
	end

	logic           vld_s2;
	pftp_pkg::fix_t m2_s2 [N_M2];
	pftp_pkg::fix_t gg_s2;
	pftp_pkg::fix_t gl_s2;
	pftp_pkg::fix_t cross_s2 [N_PAIR];
	pftp_pkg::fix_t aphi_s2;
	pftp_pkg::fix_t klap_s2;
	pftp_pkg::fix_t cbih_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		m2_s2    <= m2_p;
		gg_s2    <= gg2;
		gl_s2    <= gl2;
		cross_s2 <= cross2;
		aphi_s2  <= m1_s1[M1_APHI];
		klap_s2  <= m1_s1[M1_KLAP];
		cbih_s2  <= m1_s1[M1_CBIH];
	end

	// stage 3: coefficient products on the second-level terms
	pftp_pkg::fix_t m3_x [N_M3];
	pftp_pkg::fix_t m3_y [N_M3];
	pftp_pkg::fix_t m3_p [N_M3];

	always_comb begin
		m3_x[M3_BPHI4] = coef.b;
		m3_y[M3_BPHI4] = m2_s2[M2_PHI4];
		m3_x[M3_BPHI3] = coef.b;
		m3_y[M3_BPHI3] = m2_s2[M2_PHI3];
		m3_x[M3_KGGS]  = coef.kappa;
		m3_y[M3_KGGS]  = gg_s2;
		m3_x[M3_CGL]   = coef.c;
		m3_y[M3_CGL]   = gl_s2;
		for (int p = 0; p < N_PAIR; p++) begin
			m3_x[M3_CCR + p] = coef.c;
			m3_y[M3_CCR + p] = cross_s2[p];
		end
	end

	for (genvar k = 0; k < N_M3; k++) begin : g_m3
		pftp_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
			.x(m3_x[k]),
			.y(m3_y[k]),
			.p(m3_p[k])
		);
	end

	logic           vld_s3;
	pftp_pkg::fix_t m3_s3 [N_M3];
	pftp_pkg::fix_t ta_s3;
	pftp_pkg::fix_t tc_s3;
	pftp_pkg::fix_t kpl_s3;
	pftp_pkg::fix_t cpb_s3;
	pftp_pkg::fix_t kgg_s3 [N_PAIR];
	pftp_pkg::fix_t aphi_s3;
	pftp_pkg::fix_t klap_s3;
	pftp_pkg::fix_t cbih_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		m3_s3   <= m3_p;
		ta_s3   <= pftp_pkg::half_q(m2_s2[M2_APHI2]);
		tc_s3   <= pftp_pkg::half_q(m2_s2[M2_CLAP2]);
		kpl_s3  <= m2_s2[M2_KPL];
		cpb_s3  <= m2_s2[M2_CPB];
		for (int p = 0; p < N_PAIR; p++) begin
			kgg_s3[p] <= m2_s2[M2_KGG + p];
		end
		aphi_s3 <= aphi_s2;
		klap_s3 <= klap_s2;
		cbih_s3 <= cbih_s2;
	end

	// stage 4: energy, potential, pressure and raw stress sums
	pftp_pkg::fix_t tb4;
	pftp_pkg::fix_t t34;
	pftp_pkg::fix_t tk4;
	pftp_pkg::fix_t fed4;
	pftp_pkg::fix_t mu4;
	pftp_pkg::fix_t p04;
	pftp_pkg::acc_t st4 [N_PAIR];

	always_comb begin
		tb4  = pftp_pkg::quarter_q(m3_s3[M3_BPHI4]);
		t34  = pftp_pkg::three_q(m3_s3[M3_BPHI4]);
		tk4  = pftp_pkg::half_q(m3_s3[M3_KGGS]);
		fed4 = pftp_pkg::sat_fix(pftp_pkg::ext_fix(ta_s3) + pftp_pkg::ext_fix(tb4)
			+ pftp_pkg::ext_fix(tk4) + pftp_pkg::ext_fix(tc_s3));
		mu4  = pftp_pkg::sat_fix(pftp_pkg::ext_fix(aphi_s3)
			+ pftp_pkg::ext_fix(m3_s3[M3_BPHI3])
			- pftp_pkg::ext_fix(klap_s3) + pftp_pkg::ext_fix(cbih_s3));
		p04  = pftp_pkg::sat_fix(pftp_pkg::ext_fix(ta_s3) + pftp_pkg::ext_fix(t34)
			- pftp_pkg::ext_fix(kpl_s3) + pftp_pkg::ext_fix(tk4)
			+ pftp_pkg::ext_fix(cpb_s3) + pftp_pkg::ext_fix(tc_s3)
			+ pftp_pkg::ext_fix(m3_s3[M3_CGL]));
		for (int p = 0; p < N_PAIR; p++) begin
			st4[p] = pftp_pkg::ext_fix(kgg_s3[p]) - pftp_pkg::ext_fix(m3_s3[M3_CCR + p]);
		end
	end

	logic           vld_s4;
	pftp_pkg::fix_t fed_s4;
	pftp_pkg::fix_t mu_s4;
	pftp_pkg::fix_t p0_s4;
	pftp_pkg::acc_t st_s4 [N_PAIR];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		fed_s4 <= fed4;
		mu_s4  <= mu4;
		p0_s4  <= p04;
		st_s4  <= st4;
	end

	// stage 5: add pressure on the diagonal, saturate, drive the beat
	pftp_pkg::fix_t st5 [N_PAIR];

	always_comb begin
		for (int p = 0; p < N_PAIR; p++) begin
			if (PA[p] == PB[p]) begin
				st5[p] = pftp_pkg::sat_fix(st_s4[p] + pftp_pkg::ext_fix(p0_s4));
			end else begin
				st5[p] = pftp_pkg::sat_fix(st_s4[p]);
			end
		end
	end

	logic              vld_s5;
	pftp_pkg::result_t res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		res_s5.free_energy    <= fed_s4;
		res_s5.chem_potential <= mu_s4;
		res_s5.stress_xx      <= st5[0];
		res_s5.stress_yy      <= st5[1];
		res_s5.stress_zz      <= st5[2];
		res_s5.stress_xy      <= st5[3];
		res_s5.stress_xz      <= st5[4];
		res_s5.stress_yz      <= st5[5];
	end

	assign out_vld = vld_s5;
	assign result  = res_s5;

endmodule

`default_nettype wire

### rtl/core/phase_field_thermo_point_top.sv
// Result: a site taken at a clock edge passes through five register stages (s1 to s5)
// and gives its result beat with done high; done lasts one cycle and the receiver cannot stall.
// Throughput: one site per cycle while busy is low, set by the five-stage multiplier pipeline.
// Reset: asynchronous, active low; clears valid bits and coefficients to zero,
// busy is set high by reset and cleared at the first clock edge after release, then low for good.
`timescale 1ns / 1ps
`default_nettype none

module phase_field_thermo_point_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pftp_pkg::site_t     site,
	output logic                done,
	output pftp_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  pftp_pkg::cfg_idx_t  cfg_index,
	input  pftp_pkg::fix_t      cfg_data
);

	logic            busy_q;
	logic            take;
	pftp_pkg::coef_t coef;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign take      = start && !busy_q;
	assign cfg_ready = 1'b1;

	pftp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	pftp_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (take),
		.site    (site),
		.coef    (coef),
		.out_vld (done),
		.result  (result)
	);

endmodule

`default_nettype wire

### rtl/core/pftp_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "phase_field_thermo_point_top_defines.svh"

module pftp_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	`PFTP_ASSERT_IMP(a_beat_follows_start, clk, arst_n, start && !busy, ##5 done)
	`PFTP_ASSERT_IMP(a_beat_has_start, clk, arst_n, done, $past(start && !busy, 5))
	`PFTP_ASSERT_NXT(a_busy_stays_low, clk, arst_n, !busy, !busy)

endmodule

bind phase_field_thermo_point_top pftp_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
